// File: hdl/trickle_gossip_timer_unit_assert.svh
// Assertion macros used by the timer top level.
`ifndef TRICKLE_GOSSIP_TIMER_UNIT_ASSERT_SVH
`define TRICKLE_GOSSIP_TIMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TGT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TGT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tgt_pkg.sv
// Types and constants shared by the gossip timer modules.
package tgt_pkg;

    localparam int CMD_W   = 2;
    localparam int IVL_W   = 16;
    localparam int HALF_W  = IVL_W - 1;
    localparam int LIMIT_W = 8;
    localparam int EV_W    = 2;
    localparam int OUT_CNT_W = 8;

    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NEW_INFO  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REDUNDANT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART   = 2'd3;

    localparam logic [EV_W-1:0] EV_NONE       = 2'd0;
    localparam logic [EV_W-1:0] EV_SENT       = 2'd1;
    localparam logic [EV_W-1:0] EV_SUPPRESSED = 2'd2;
    localparam logic [EV_W-1:0] EV_PRUNE      = 2'd3;

    localparam logic [1:0] REG_INTERVAL_LOW  = 2'd0;
    localparam logic [1:0] REG_INTERVAL_HIGH = 2'd1;
    localparam logic [1:0] REG_REDUND_LIMIT  = 2'd2;

    localparam logic [IVL_W-1:0]   RST_INTERVAL_LOW  = 16'd64;
    localparam logic [IVL_W-1:0]   RST_INTERVAL_HIGH = 16'd4096;
    localparam logic [LIMIT_W-1:0] RST_REDUND_LIMIT  = 8'd3;

    // The remainder unit retires one dividend bit per step.
    localparam int DIV_STEPS = IVL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_START,
        ST_DRAW,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [IVL_W-1:0]   interval_low;
        logic [IVL_W-1:0]   interval_high;
        logic [LIMIT_W-1:0] redundancy_limit;
    } t_cfg;

endpackage

// File: hdl/tgt_cfg_regs.sv
// Configuration register file behind the APB-style port.
module tgt_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [3:0]        i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output tgt_pkg::t_cfg     o_cfg
);

    tgt_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval_low     <= tgt_pkg::RST_INTERVAL_LOW;
            r_cfg.interval_high    <= tgt_pkg::RST_INTERVAL_HIGH;
            r_cfg.redundancy_limit <= tgt_pkg::RST_REDUND_LIMIT;
        end else if (w_wr) begin
            case (i_paddr[3:2])
                tgt_pkg::REG_INTERVAL_LOW: begin
                    r_cfg.interval_low <= i_pwdata[tgt_pkg::IVL_W-1:0];
                end
                tgt_pkg::REG_INTERVAL_HIGH: begin
                    r_cfg.interval_high <= i_pwdata[tgt_pkg::IVL_W-1:0];
                end
                tgt_pkg::REG_REDUND_LIMIT: begin
                    r_cfg.redundancy_limit <= i_pwdata[tgt_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            tgt_pkg::REG_INTERVAL_LOW:  o_prdata = 32'(r_cfg.interval_low);
            tgt_pkg::REG_INTERVAL_HIGH: o_prdata = 32'(r_cfg.interval_high);
            tgt_pkg::REG_REDUND_LIMIT:  o_prdata = 32'(r_cfg.redundancy_limit);
            default:                    o_prdata = 32'd0;
        endcase
    end

endmodule

// File: hdl/tgt_divider.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module tgt_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tgt_pkg::IVL_W-1:0]   i_dividend,
    input  logic [tgt_pkg::HALF_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [tgt_pkg::HALF_W-1:0]  o_rem
);

    logic                           r_busy;
    logic                           r_done;
    logic [tgt_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [tgt_pkg::IVL_W-1:0]      r_dvd;
    logic [tgt_pkg::IVL_W-1:0]      r_rem;
    logic [tgt_pkg::HALF_W-1:0]     r_div;
    logic [tgt_pkg::IVL_W-1:0]      w_trial;
    logic [tgt_pkg::IVL_W-1:0]      w_div_ext;
    logic [tgt_pkg::IVL_W-1:0]      w_rem_next;

    // The partial remainder stays below the divisor, so one shifted bit fits.
    assign w_trial    = {r_rem[tgt_pkg::IVL_W-2:0], r_dvd[tgt_pkg::IVL_W-1]};
    assign w_div_ext  = {1'b0, r_div};
    assign w_rem_next = (w_trial >= w_div_ext) ? (w_trial - w_div_ext) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + tgt_pkg::DIV_CNT_W'(1);
                if (r_cnt == tgt_pkg::DIV_CNT_W'(tgt_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[tgt_pkg::IVL_W-2:0], 1'b0};
            r_rem <= w_rem_next;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[tgt_pkg::HALF_W-1:0];

endmodule

// File: hdl/trickle_gossip_timer_unit.sv
// Trickle-style adaptive gossip timer, top level.
//
// The timer takes one event word at a time on the slave stream (tick, reception
// with new information, redundant reception, restart) and returns exactly one
// result word on the master stream for each. A tick, a redundant reception or
// an expiry that ends in a prune reset goes from an evaluate state straight to
// the result register. An item that draws a new countdown (an expiry that sends
// or suppresses, a new-info reception or a restart) goes from evaluation through
// a start state and the one-bit steps of the remainder unit, which forms rand mod
// (interval/2), before it reaches the result register. The input is not ready
// while an item is in work; a finished result sits in an output register, and
// the block waits only if that register is still full when the next result is
// ready. Configuration registers are written through the APB-style port at byte
// addresses 0 (interval_low), 4 (interval_high) and 8 (redundancy_limit); they
// should be written only while the timer is idle.
module trickle_gossip_timer_unit #(
    parameter int TIME_BITS  = 16,
    parameter int COUNT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] rand_value, [16] prune_request, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    // Master stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] interval_now, [31:16] countdown_now,
                                        // [32] armed_now, [40:33] redundant_now, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] event_res
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "trickle_gossip_timer_unit_assert.svh"

    localparam int CMP_W = (COUNT_BITS > tgt_pkg::OUT_CNT_W) ? COUNT_BITS : tgt_pkg::OUT_CNT_W;

    tgt_pkg::t_cfg  w_cfg;
    tgt_pkg::t_state r_state;
    tgt_pkg::t_state n_state;

    // Latched input word.
    logic [tgt_pkg::CMD_W-1:0]  r_cmd;
    logic [tgt_pkg::IVL_W-1:0]  r_rand;
    logic                       r_prune;

    // Timer state.
    logic [tgt_pkg::IVL_W-1:0]  r_interval;
    logic [tgt_pkg::IVL_W-1:0]  r_countdown;
    logic                       r_armed;
    logic [COUNT_BITS-1:0]      r_count;
    logic [TIME_BITS-1:0]       r_time;
    logic [TIME_BITS-1:0]       r_last;
    logic [tgt_pkg::EV_W-1:0]   r_event;

    // Output register.
    logic                           r_out_valid;
    logic [tgt_pkg::EV_W-1:0]       r_out_event;
    logic [tgt_pkg::IVL_W-1:0]      r_out_interval;
    logic [tgt_pkg::IVL_W-1:0]      r_out_countdown;
    logic                           r_out_armed;
    logic [tgt_pkg::OUT_CNT_W-1:0]  r_out_count;

    // Control strobes.
    logic w_accept;
    logic w_div_start;
    logic w_out_load;
    logic w_out_free;

    // Datapath terms.
    logic [TIME_BITS-1:0]           w_time_inc;
    logic [tgt_pkg::IVL_W-1:0]      w_cd_dec;
    logic                           w_expire;
    logic                           w_prune;
    logic [tgt_pkg::IVL_W:0]        w_doubled;
    logic [tgt_pkg::IVL_W-1:0]      w_interval_dbl;
    logic [CMP_W-1:0]               w_count_ext;
    logic                           w_suppress;
    logic [tgt_pkg::HALF_W-1:0]     w_half;
    logic                           w_div_done;
    logic [tgt_pkg::HALF_W-1:0]     w_rem;
    logic [tgt_pkg::IVL_W-1:0]      w_sum;
    logic [tgt_pkg::IVL_W-1:0]      w_draw;
    logic                           w_keep;

    tgt_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    assign pready = 1'b1;

    // The countdown draw divides the random word by half the current interval.
    assign w_half = r_interval[tgt_pkg::IVL_W-1:1];

    tgt_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rand),
        .i_divisor  (w_half),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // Tick and expiry terms, evaluated in the cycle after acceptance.
    assign w_time_inc = r_time + TIME_BITS'(1);
    assign w_cd_dec   = (r_countdown != '0) ? (r_countdown - tgt_pkg::IVL_W'(1)) : r_countdown;
    assign w_expire   = r_armed && (w_cd_dec == '0);
    assign w_prune    = (w_time_inc < r_last) && r_prune;

    // Doubling saturates at the ceiling as programmed, even below the floor.
    assign w_doubled      = {r_interval, 1'b0};
    assign w_interval_dbl = (w_doubled > {1'b0, w_cfg.interval_high}) ?
                            w_cfg.interval_high : w_doubled[tgt_pkg::IVL_W-1:0];

    assign w_count_ext = CMP_W'(r_count);
    assign w_suppress  = w_count_ext >= CMP_W'(w_cfg.redundancy_limit);

    // A zero half drops the modulo term, and a zero draw is bumped to one.
    assign w_sum  = {1'b0, w_half} + ((w_half != '0) ? {1'b0, w_rem} : '0);
    assign w_draw = (w_sum == '0) ? tgt_pkg::IVL_W'(1) : w_sum;
    assign w_keep = (r_cmd != tgt_pkg::CMD_TICK) && r_armed && (r_countdown < w_draw);

    assign w_out_free = !r_out_valid || m_axis_tready;

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tgt_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = tgt_pkg::ST_EVAL;
                end
            end
            tgt_pkg::ST_EVAL: begin
                case (r_cmd)
                    tgt_pkg::CMD_TICK: begin
                        n_state = (w_expire && !w_prune) ? tgt_pkg::ST_START : tgt_pkg::ST_DONE;
                    end
                    tgt_pkg::CMD_REDUNDANT: begin
                        n_state = tgt_pkg::ST_DONE;
                    end
                    default: begin
                        n_state = tgt_pkg::ST_START;
                    end
                endcase
            end
            tgt_pkg::ST_START: begin
                n_state = tgt_pkg::ST_DRAW;
            end
            tgt_pkg::ST_DRAW: begin
                if (w_div_done) begin
                    n_state = tgt_pkg::ST_DONE;
                end
            end
            tgt_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = tgt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tgt_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: strobes.
    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            tgt_pkg::ST_IDLE:  s_axis_tready = 1'b1;
            tgt_pkg::ST_START: w_div_start   = 1'b1;
            tgt_pkg::ST_DONE:  w_out_load    = w_out_free;
            default: begin
            end
        endcase
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= s_axis_tuser;
            r_rand  <= s_axis_tdata[tgt_pkg::IVL_W-1:0];
            r_prune <= s_axis_tdata[tgt_pkg::IVL_W];
        end
    end

    // Timer state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= '0;
            r_countdown <= '0;
            r_armed     <= 1'b0;
            r_count     <= '0;
            r_time      <= '0;
            r_last      <= '0;
            r_event     <= tgt_pkg::EV_NONE;
        end else if (r_state == tgt_pkg::ST_EVAL) begin
            r_event <= tgt_pkg::EV_NONE;
            case (r_cmd)
                tgt_pkg::CMD_TICK: begin
                    r_time <= w_time_inc;
                    if (r_armed) begin
                        r_countdown <= w_cd_dec;
                    end
                    if (w_expire) begin
                        if (w_prune) begin
                            // Time wrapped below the last broadcast: back off and disarm.
                            r_count     <= '0;
                            r_interval  <= w_cfg.interval_low;
                            r_countdown <= '0;
                            r_armed     <= 1'b0;
                            r_event     <= tgt_pkg::EV_PRUNE;
                        end else begin
                            r_last     <= w_time_inc;
                            r_interval <= w_interval_dbl;
                            if (w_suppress) begin
                                r_count <= '0;
                                r_event <= tgt_pkg::EV_SUPPRESSED;
                            end else begin
                                r_event <= tgt_pkg::EV_SENT;
                            end
                        end
                    end
                end
                tgt_pkg::CMD_REDUNDANT: begin
                    if (r_count != '1) begin
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                end
                default: begin
                    r_count    <= '0;
                    r_interval <= w_cfg.interval_low;
                end
            endcase
        end else if (r_state == tgt_pkg::ST_DRAW && w_div_done) begin
            // A new-info reception or a restart leaves an earlier pending expiry in place.
            if (!w_keep) begin
                r_countdown <= w_draw;
                r_armed     <= 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_event     <= r_event;
            r_out_interval  <= r_interval;
            r_out_countdown <= r_armed ? r_countdown : '0;
            r_out_armed     <= r_armed;
            r_out_count     <= w_count_ext[tgt_pkg::OUT_CNT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_event;
    assign m_axis_tdata  = {7'd0, r_out_count, r_out_armed, r_out_countdown, r_out_interval};

    // An armed timer at rest always has time left to run.
    `TGT_ASSERT_NOW(a_armed_nonzero, (r_state == tgt_pkg::ST_IDLE) && r_armed, r_countdown != '0, "armed timer idle with zero countdown")
    // An accepted word is evaluated in the next cycle.
    `TGT_ASSERT_NEXT(a_accept_eval, w_accept, r_state == tgt_pkg::ST_EVAL, "accepted word not evaluated")
    // The remainder unit finishes only while the sequencer waits for it.
    `TGT_ASSERT_NOW(a_div_done_draw, w_div_done, r_state == tgt_pkg::ST_DRAW, "remainder finished outside draw")
    // A suppressed broadcast always reports a cleared redundancy count.
    `TGT_ASSERT_NOW(a_suppress_clear, r_out_valid && (r_out_event == tgt_pkg::EV_SUPPRESSED), r_out_count == '0, "suppression without cleared count")

endmodule
